/* rtl/skt_pkg.sv */
// Shared types and codes of the key table unit.
package skt_pkg;

    localparam int KEY_W  = 32;
    localparam int ACT_W  = 3;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 7;

    typedef logic signed [KEY_W-1:0] t_key;
    typedef logic [ACT_W-1:0]        t_action;
    typedef logic [STAT_W-1:0]       t_status;
    typedef logic [CNT_W-1:0]        t_entry_count;

    // Action codes of a request transaction.
    localparam t_action ACT_INSERT = 3'd0;
    localparam t_action ACT_REMOVE = 3'd1;
    localparam t_action ACT_SEARCH = 3'd2;
    localparam t_action ACT_MIN    = 3'd3;
    localparam t_action ACT_MAX    = 3'd4;
    localparam t_action ACT_PRED   = 3'd5;
    localparam t_action ACT_SUCC   = 3'd6;

    // Status codes of a response transaction.
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_NONE  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;
    localparam t_status ST_FULL  = 2'd3;

endpackage

/* rtl/skt_if.sv */
// Request and response channel interfaces of the key table unit.
interface skt_req_if;
    logic              valid;
    logic              ready;
    skt_pkg::t_action  action;
    skt_pkg::t_key     key;

    modport source (output valid, output action, output key, input ready);
    modport sink   (input valid, input action, input key, output ready);
endinterface

interface skt_rsp_if;
    logic                  valid;
    logic                  ready;
    skt_pkg::t_status      status;
    skt_pkg::t_key         result_key;
    skt_pkg::t_entry_count entry_count;

    modport source (output valid, output status, output result_key, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input result_key, input entry_count,
                    output ready);
endinterface

/* rtl/sorted_or_unsorted_key_table_unit.sv */
// Key table unit: sorted or arrival-order key store with a sequenced compare unit.
//
//   channel   dir  handshake      payload
//   i_req     in   valid/ready    action[2:0], key[31:0] signed
//   o_rsp     out  valid/ready    status[1:0], result_key[31:0] signed, entry_count[6:0]
//   i_cfg_*   in   write enable   wr_data: sorted_mode (1 = ascending order)
//
// One transaction is worked on at a time; i_req.ready is high only while the sequencer idles.
// Unsorted insert, insert into an empty table and rejected actions go straight to completion;
// sorted min/max read one end entry; sorted insert, remove and unsorted search/min/max/pred/succ
// walk the stored keys, and sorted search, predecessor and successor use a binary search;
// the single memory read port, one entry per cycle, paces these walks.
// Reset clears the count and the sequencer and sets sorted_mode; the key memory is not cleared.
// A response waiting in the output register does not block the next request; only the
// completion of that next transaction waits for o_rsp.ready.
module sorted_or_unsorted_key_table_unit #(
    parameter int DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    skt_req_if.sink    i_req,
    skt_rsp_if.source  o_rsp
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_INS,
        S_INS_HEAD,
        S_BS_RD,
        S_BS_CMP,
        S_NBR,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_lo, n_lo;
    logic [CW-1:0] r_hip, n_hip;
    logic r_sorted;
    logic r_have, n_have;
    skt_pkg::t_action r_action, n_action;
    skt_pkg::t_key r_key, n_key;
    skt_pkg::t_key r_best, n_best;
    skt_pkg::t_status r_status, n_status;
    skt_pkg::t_key r_res, n_res;

    logic r_out_valid;
    skt_pkg::t_status r_out_status;
    skt_pkg::t_key r_out_key;
    skt_pkg::t_entry_count r_out_cnt;
    logic out_load;

    // Key memory with one write port and one registered read port.
    skt_pkg::t_key r_mem [DEPTH];
    skt_pkg::t_key r_rd_data;
    logic mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    skt_pkg::t_key mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    // Index arithmetic shared by the sequencer.
    logic [CW-1:0] idx_inc, idx_inc2, idx_dec, cnt_dec, cnt_inc;
    logic [CW:0] bs_sum;
    logic [CW-1:0] bs_mid;
    logic last;

    assign idx_inc  = r_idx + CW'(1);
    assign idx_inc2 = r_idx + CW'(2);
    assign idx_dec  = r_idx - CW'(1);
    assign cnt_dec  = r_count - CW'(1);
    assign cnt_inc  = r_count + CW'(1);
    assign bs_sum   = {1'b0, r_lo} + {1'b0, r_hip} - (CW + 1)'(1);
    assign bs_mid   = bs_sum[CW:1];
    assign last     = (idx_inc == r_count);

    // Compare unit: the word just read against the operand and the best so far.
    logic cmp_eq, rd_lt_key, key_lt_rd, rd_lt_best, best_lt_rd;
    logic sel_better, pred_cand;

    assign cmp_eq     = (r_rd_data == r_key);
    assign rd_lt_key  = (r_rd_data < r_key);
    assign key_lt_rd  = (r_key < r_rd_data);
    assign rd_lt_best = (r_rd_data < r_best);
    assign best_lt_rd = (r_best < r_rd_data);

    always_comb begin
        sel_better = 1'b0;
        pred_cand  = 1'b0;
        unique case (r_action)
            skt_pkg::ACT_MIN:  sel_better = !r_have || rd_lt_best;
            skt_pkg::ACT_MAX:  sel_better = !r_have || best_lt_rd;
            skt_pkg::ACT_PRED: begin
                pred_cand  = rd_lt_key;
                sel_better = !r_have || best_lt_rd;
            end
            skt_pkg::ACT_SUCC: begin
                pred_cand  = key_lt_rd;
                sel_better = !r_have || rd_lt_best;
            end
            default: begin
                sel_better = 1'b0;
                pred_cand  = 1'b0;
            end
        endcase
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign out_load = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);

    // Sequencer next-state and memory control.
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_lo      = r_lo;
        n_hip     = r_hip;
        n_have    = r_have;
        n_action  = r_action;
        n_key     = r_key;
        n_best    = r_best;
        n_status  = r_status;
        n_res     = r_res;
        mem_we    = 1'b0;
        mem_waddr = r_idx[AW-1:0];
        mem_wdata = r_rd_data;
        mem_raddr = r_idx[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_action = i_req.action;
                    n_key    = i_req.key;
                    n_idx    = '0;
                    n_lo     = '0;
                    n_hip    = r_count;
                    n_have   = 1'b0;
                    n_status = skt_pkg::ST_NONE;
                    n_res    = '0;
                    n_state  = S_DONE;
                    mem_raddr = '0;
                    unique case (i_req.action)
                        skt_pkg::ACT_INSERT: begin
                            if (r_count == DEPTH_C) begin
                                n_status = skt_pkg::ST_FULL;
                            end else if (!r_sorted || r_count == '0) begin
                                mem_we    = 1'b1;
                                mem_waddr = r_count[AW-1:0];
                                mem_wdata = i_req.key;
                                n_count   = cnt_inc;
                                n_status  = skt_pkg::ST_OK;
                                n_res     = i_req.key;
                            end else begin
                                mem_raddr = cnt_dec[AW-1:0];
                                n_idx     = cnt_dec;
                                n_state   = S_INS;
                            end
                        end
                        skt_pkg::ACT_REMOVE: begin
                            if (r_count != '0) begin
                                n_state = S_SCAN;
                            end
                        end
                        skt_pkg::ACT_SEARCH, skt_pkg::ACT_PRED, skt_pkg::ACT_SUCC: begin
                            if (r_count != '0) begin
                                n_state = r_sorted ? S_BS_RD : S_SCAN;
                            end
                        end
                        skt_pkg::ACT_MIN, skt_pkg::ACT_MAX: begin
                            if (r_count == '0) begin
                                n_status = skt_pkg::ST_EMPTY;
                            end else if (r_sorted) begin
                                if (i_req.action == skt_pkg::ACT_MAX) begin
                                    mem_raddr = cnt_dec[AW-1:0];
                                end
                                n_state = S_NBR;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_status = skt_pkg::ST_NONE;
                        end
                    endcase
                end
            end

            // Linear walk: read the next entry while the compare unit checks this one.
            S_SCAN: begin
                mem_raddr = idx_inc[AW-1:0];
                n_idx     = idx_inc;
                unique case (r_action)
                    skt_pkg::ACT_REMOVE: begin
                        if (cmp_eq) begin
                            n_status = skt_pkg::ST_OK;
                            n_res    = r_key;
                            if (last) begin
                                n_count = cnt_dec;
                                n_state = S_DONE;
                            end else begin
                                n_idx   = r_idx;
                                n_state = S_SHIFT;
                            end
                        end else if (last) begin
                            n_state = S_DONE;
                        end
                    end
                    skt_pkg::ACT_SEARCH: begin
                        if (cmp_eq) begin
                            n_status = skt_pkg::ST_OK;
                            n_res    = r_key;
                            n_state  = S_DONE;
                        end else if (last) begin
                            n_state = S_DONE;
                        end
                    end
                    skt_pkg::ACT_MIN, skt_pkg::ACT_MAX: begin
                        n_have = 1'b1;
                        n_best = sel_better ? r_rd_data : r_best;
                        if (last) begin
                            n_status = skt_pkg::ST_OK;
                            n_res    = sel_better ? r_rd_data : r_best;
                            n_state  = S_DONE;
                        end
                    end
                    skt_pkg::ACT_PRED, skt_pkg::ACT_SUCC: begin
                        if (pred_cand && sel_better) begin
                            n_best = r_rd_data;
                            n_have = 1'b1;
                        end
                        if (last) begin
                            if (r_have || pred_cand) begin
                                n_status = skt_pkg::ST_OK;
                                n_res    = (pred_cand && sel_better) ? r_rd_data : r_best;
                            end
                            n_state = S_DONE;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end

            // Close the gap left by a removed key, one entry per cycle.
            S_SHIFT: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx[AW-1:0];
                mem_wdata = r_rd_data;
                if (idx_inc2 < r_count) begin
                    mem_raddr = idx_inc2[AW-1:0];
                    n_idx     = idx_inc;
                end else begin
                    n_count = cnt_dec;
                    n_state = S_DONE;
                end
            end

            // Sorted insert: move larger keys up by one until the slot is found.
            S_INS: begin
                mem_we    = 1'b1;
                mem_waddr = idx_inc[AW-1:0];
                if (key_lt_rd) begin
                    mem_wdata = r_rd_data;
                    if (r_idx == '0) begin
                        n_state = S_INS_HEAD;
                    end else begin
                        mem_raddr = idx_dec[AW-1:0];
                        n_idx     = idx_dec;
                    end
                end else begin
                    mem_wdata = r_key;
                    n_count   = cnt_inc;
                    n_status  = skt_pkg::ST_OK;
                    n_res     = r_key;
                    n_state   = S_DONE;
                end
            end

            S_INS_HEAD: begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = r_key;
                n_count   = cnt_inc;
                n_status  = skt_pkg::ST_OK;
                n_res     = r_key;
                n_state   = S_DONE;
            end

            // Binary search: issue the middle read, then compare and narrow.
            S_BS_RD: begin
                if (r_lo < r_hip) begin
                    mem_raddr = bs_mid[AW-1:0];
                    n_idx     = bs_mid;
                    n_state   = S_BS_CMP;
                end else begin
                    n_state = S_DONE;
                end
            end

            S_BS_CMP: begin
                if (cmp_eq) begin
                    n_state = S_DONE;
                    unique case (r_action)
                        skt_pkg::ACT_SEARCH: begin
                            n_status = skt_pkg::ST_OK;
                            n_res    = r_key;
                        end
                        skt_pkg::ACT_PRED: begin
                            if (r_idx != '0) begin
                                mem_raddr = idx_dec[AW-1:0];
                                n_state   = S_NBR;
                            end
                        end
                        skt_pkg::ACT_SUCC: begin
                            if (idx_inc < r_count) begin
                                mem_raddr = idx_inc[AW-1:0];
                                n_state   = S_NBR;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end else if (key_lt_rd) begin
                    n_hip   = r_idx;
                    n_state = S_BS_RD;
                end else begin
                    n_lo    = idx_inc;
                    n_state = S_BS_RD;
                end
            end

            // The word just read is the answer.
            S_NBR: begin
                n_status = skt_pkg::ST_OK;
                n_res    = r_rd_data;
                n_state  = S_DONE;
            end

            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, working registers and the response register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_sorted    <= 1'b1;
            r_out_valid <= 1'b0;
            r_have      <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_have   <= n_have;
            r_idx    <= n_idx;
            r_lo     <= n_lo;
            r_hip    <= n_hip;
            r_action <= n_action;
            r_key    <= n_key;
            r_best   <= n_best;
            r_status <= n_status;
            r_res    <= n_res;
            if (i_cfg_wr_en) begin
                r_sorted <= i_cfg_wr_data;
            end
            if (out_load) begin
                r_out_valid  <= 1'b1;
                r_out_status <= r_status;
                r_out_key    <= r_res;
                r_out_cnt    <= skt_pkg::CNT_W'(r_count);
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.result_key  = r_out_key;
    assign o_rsp.entry_count = r_out_cnt;

    // The table never holds more keys than it has room for.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("key count exceeds table depth");

    // The count only moves when a transaction completes.
    a_count_at_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_count != $past(r_count)) |-> r_state == S_DONE)
        else $error("key count changed outside completion");

    // A full status is only reported while the table is full.
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(out_load) && $past(i_rst_n) && o_rsp.status == skt_pkg::ST_FULL)
            |-> r_count == DEPTH_C)
        else $error("full status reported with room left");

    // A new response is only loaded on leaving the completion state.
    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> r_state == S_IDLE && r_out_valid)
        else $error("response load did not complete");

endmodule
